@@ hw/rtl/psa_pkg.sv @@
// Shared types and constants for the pair stress accumulator.
// No dependencies; every other file but psa_if imports this package.
`default_nettype none

package psa_pkg;

	localparam int ACC_WIDTH_DEF = 48;
	localparam int OUT_WIDTH     = 48;
	localparam int QUEUE_DEPTH   = 2;
	localparam int DIV_BITS      = 49;
	localparam int ROOT_STEPS    = 32;

	localparam logic [63:0] LIM = 64'h0FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] BIG = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		REG_INNER  = 3'd0,
		REG_CUTOFF = 3'd1,
		REG_WELL   = 3'd2,
		REG_SIGMA  = 3'd3,
		REG_CUBIC  = 3'd4,
		REG_SQUARE = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {SH_16, SH_24, SH_32} shift_t;
	typedef enum logic {LIM_SAT, BIG_SAT} sat_lim_t;
	typedef enum logic {OP_ROOT, OP_DIV} iter_op_t;

	typedef struct packed {
		logic signed [31:0] inner_radius;
		logic signed [31:0] cutoff_radius;
		logic signed [31:0] well_depth;
		logic signed [31:0] sigma_length;
		logic signed [31:0] spline_cubic;
		logic signed [31:0] spline_square;
	} cfg_t;

	typedef struct packed {
		logic signed [63:0] xx;
		logic signed [63:0] xy;
		logic signed [63:0] yy;
		logic [63:0]        r2;
		logic               ovf;
		logic               last;
	} pair_t;

	typedef struct packed {
		logic        start;
		iter_op_t    op;
		logic [63:0] root_in;
		logic [48:0] num;
		logic [31:0] den;
	} iter_req_t;

	typedef struct packed {
		logic        done;
		logic [48:0] res;
	} iter_rsp_t;

	typedef struct packed {
		logic               start;
		shift_t             shift;
		sat_lim_t           lim;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic               sat;
		logic signed [63:0] res;
	} mul_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/psa_if.sv @@
// Handshake channels of the pair stress accumulator: items, results, config writes.
// No dependencies.
`default_nettype none

interface psa_item_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [31:0] neighbor_x;
	logic signed [31:0] neighbor_y;
	logic               last_neighbor;
	modport source (output valid, center_x, center_y, neighbor_x, neighbor_y, last_neighbor,
		input ready);
	modport sink (input valid, center_x, center_y, neighbor_x, neighbor_y, last_neighbor,
		output ready);
	modport monitor (input valid, ready, center_x, center_y, neighbor_x, neighbor_y,
		last_neighbor);
endinterface

interface psa_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] stress_xx;
	logic signed [47:0] stress_xy;
	logic signed [47:0] stress_yx;
	logic signed [47:0] stress_yy;
	logic               overflow;
	modport source (output valid, stress_xx, stress_xy, stress_yx, stress_yy, overflow,
		input ready);
	modport sink (input valid, stress_xx, stress_xy, stress_yx, stress_yy, overflow,
		output ready);
	modport monitor (input valid, ready, stress_xx, stress_xy, stress_yx, stress_yy,
		overflow);
endinterface

interface psa_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport monitor (input valid, ready, index, data);
endinterface

`default_nettype wire

@@ hw/rtl/psa_front.sv @@
// Front end: takes items, forms saturated differences and their exact products.
// Depends on psa_pkg and psa_if.
`default_nettype none

module psa_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	psa_item_if.sink      item,
	output logic          push_valid,
	input  wire logic     push_ready,
	output psa_pkg::pair_t push_data
);
	import psa_pkg::*;

	logic               v_s1, v_s2;
	logic signed [31:0] dx_s1, dy_s1;
	logic               ovf_s1, last_s1;
	logic signed [63:0] xx_s2, xy_s2, yy_s2;
	logic               ovf_s2, last_s2;
	logic               take_s1, take_s2;
	logic signed [32:0] dx_w, dy_w;
	logic               sat_x, sat_y;
	logic signed [31:0] dx_c, dy_c;
	logic signed [63:0] xx_w, xy_w, yy_w;

	assign take_s2 = ~v_s2 | push_ready;
	assign take_s1 = ~v_s1 | take_s2;
	assign item.ready = take_s1;

	assign dx_w  = {item.center_x[31], item.center_x} - {item.neighbor_x[31], item.neighbor_x};
	assign dy_w  = {item.center_y[31], item.center_y} - {item.neighbor_y[31], item.neighbor_y};
	assign sat_x = dx_w[32] != dx_w[31];
	assign sat_y = dy_w[32] != dy_w[31];
	assign dx_c  = sat_x ? (dx_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dx_w[31:0];
	assign dy_c  = sat_y ? (dy_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dy_w[31:0];

	assign xx_w = dx_s1 * dx_s1;
	assign xy_w = dx_s1 * dy_s1;
	assign yy_w = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take_s1) v_s1 <= item.valid;
			if (take_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && item.valid) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			ovf_s1  <= sat_x | sat_y;
			last_s1 <= item.last_neighbor;
		end
		if (take_s2 && v_s1) begin
			xx_s2   <= xx_w;
			xy_s2   <= xy_w;
			yy_s2   <= yy_w;
			ovf_s2  <= ovf_s1;
			last_s2 <= last_s1;
		end
	end

	assign push_valid     = v_s2;
	assign push_data.xx   = xx_s2;
	assign push_data.xy   = xy_s2;
	assign push_data.yy   = yy_s2;
	assign push_data.r2   = unsigned'(xx_s2) + unsigned'(yy_s2);
	assign push_data.ovf  = ovf_s2;
	assign push_data.last = last_s2;

endmodule

`default_nettype wire

@@ hw/rtl/psa_queue.sv @@
// Short item queue between front end and back end.
// Depends on psa_pkg.
`default_nettype none

module psa_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire psa_pkg::pair_t push_data,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output psa_pkg::pair_t      pop_data
);
	import psa_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	pair_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           push, pop;

	assign push_ready = cnt_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rd_q];
	assign push = push_valid & push_ready;
	assign pop  = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ hw/rtl/psa_iter.sv @@
// Iterative unit: integer square root (two bits per step) or restoring divide
// (one quotient bit per step). Depends on psa_pkg.
`default_nettype none

module psa_iter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psa_pkg::iter_req_t req,
	output psa_pkg::iter_rsp_t      rsp
);
	import psa_pkg::*;

	localparam int CNT_W = $clog2(DIV_BITS);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q, last_w;
	iter_op_t         op_q;
	logic [63:0]      v_q, res_q, probe_q, trial_w;
	logic [48:0]      num_q, quo_q;
	logic [31:0]      den_q, rem_q;
	logic [32:0]      rem_sh;
	logic             root_ge, div_ge;

	assign last_w  = (op_q == OP_ROOT) ? CNT_W'(ROOT_STEPS - 1) : CNT_W'(DIV_BITS - 1);
	assign trial_w = res_q + probe_q;
	assign root_ge = v_q >= trial_w;
	assign rem_sh  = {rem_q, num_q[48]};
	assign div_ge  = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == last_w) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q    <= req.op;
			v_q     <= req.root_in;
			res_q   <= '0;
			probe_q <= 64'h4000_0000_0000_0000;
			num_q   <= req.num;
			den_q   <= req.den;
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (busy_q) begin
			if (op_q == OP_ROOT) begin
				if (root_ge) begin
					v_q   <= v_q - trial_w;
					res_q <= (res_q >> 1) + probe_q;
				end else begin
					res_q <= res_q >> 1;
				end
				probe_q <= probe_q >> 2;
			end else begin
				rem_q <= div_ge ? rem_sh[31:0] - den_q : rem_sh[31:0];
				quo_q <= {quo_q[47:0], div_ge};
				num_q <= {num_q[47:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == OP_ROOT) ? res_q[48:0] : quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/psa_mul.sv @@
// Saturating fixed-point multiplier: 64x64 magnitude product built from four
// 32x32 partial products, shifted, truncated and clamped. Depends on psa_pkg.
`default_nettype none

module psa_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire psa_pkg::mul_req_t req,
	output psa_pkg::mul_rsp_t      rsp
);
	import psa_pkg::*;

	logic         busy_q, done_q, ppv_s1;
	logic [2:0]   cnt_q;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	shift_t       sh_q;
	sat_lim_t     lim_q;
	logic [63:0]  pp_s1;
	logic [1:0]   pos_s1;
	logic [127:0] acc_q;
	logic         sat_q;
	logic signed [63:0] res_q;

	logic [31:0]  ha, hb;
	logic [63:0]  pp_w, lim_v, mag_w;
	logic [1:0]   place;
	logic [127:0] pp_ext, shifted;
	logic         sat_w;

	assign ha    = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign hb    = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp_w  = ha * hb;
	assign place = {1'b0, pos_s1[1]} + {1'b0, pos_s1[0]};
	assign lim_v = (lim_q == BIG_SAT) ? BIG : LIM;

	always_comb begin
		unique case (place)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_ext = {pp_s1, 64'd0};
			default: pp_ext = '0;
		endcase
		unique case (sh_q)
			SH_16:   shifted = acc_q >> 16;
			SH_24:   shifted = acc_q >> 24;
			SH_32:   shifted = acc_q >> 32;
			default: shifted = acc_q >> 32;
		endcase
		sat_w = (|shifted[127:64]) | (shifted[63:0] > lim_v);
		mag_w = sat_w ? lim_v : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ppv_s1 <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				ppv_s1 <= 1'b0;
			end else if (busy_q) begin
				ppv_s1 <= cnt_q < 3'd4;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= req.a[63] ? unsigned'(-req.a) : unsigned'(req.a);
			mb_q  <= req.b[63] ? unsigned'(-req.b) : unsigned'(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			sh_q  <= req.shift;
			lim_q <= req.lim;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_s1  <= pp_w;
				pos_s1 <= cnt_q[1:0];
			end
			if (ppv_s1) acc_q <= acc_q + pp_ext;
			if (cnt_q == 3'd5) begin
				sat_q <= sat_w;
				res_q <= neg_q ? -$signed(mag_w) : $signed(mag_w);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.res  = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/psa_back.sv @@
// Back end: sequences root, divides and multiplies for one pair, accumulates the
// tensor and holds the result register. Depends on psa_pkg and psa_if.
`default_nettype none

module psa_back #(
	parameter int ACC_WIDTH = psa_pkg::ACC_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psa_pkg::cfg_t      cfg,
	input  wire logic               pop_valid,
	output logic                    pop_ready,
	input  wire psa_pkg::pair_t     pop_data,
	output psa_pkg::iter_req_t      iter_req,
	input  wire psa_pkg::iter_rsp_t iter_rsp,
	output psa_pkg::mul_req_t       mul_req,
	input  wire psa_pkg::mul_rsp_t  mul_rsp,
	psa_result_if.source            result
);
	import psa_pkg::*;

	localparam logic signed [63:0] ACC_MAX =
		{{(65 - ACC_WIDTH){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
	localparam logic signed [63:0] ACC_MIN = ~ACC_MAX;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ROOT  = 6'b000010,
		ST_RECIP = 6'b000100,
		ST_QUOT  = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		MS_P2, MS_P3, MS_P6, MS_P12, MS_NUM, MS_DLJ, MS_D2, MS_T1, MS_T2,
		MS_GXX, MS_TXX, MS_GXY, MS_TXY, MS_GYY, MS_TYY
	} step_t;

	function automatic logic [64:0] clamp_lim(input logic signed [63:0] x);
		logic signed [63:0] hi;
		hi = $signed(LIM);
		if (x > hi)       return {1'b1, hi};
		else if (x < -hi) return {1'b1, -hi};
		else              return {1'b0, x};
	endfunction

	function automatic logic [ACC_WIDTH:0] sat_add(input logic signed [ACC_WIDTH-1:0] a,
		input logic signed [ACC_WIDTH-1:0] b);
		logic signed [ACC_WIDTH:0] s;
		s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
			return {1'b1, s[ACC_WIDTH], {(ACC_WIDTH - 1){~s[ACC_WIDTH]}}};
		else
			return {1'b0, s[ACC_WIDTH-1:0]};
	endfunction

	function automatic logic [48:0] narrow_out(input logic signed [ACC_WIDTH-1:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (w > OUT_MAX)       return {1'b1, OUT_MAX[47:0]};
		else if (w < ~OUT_MAX) return {1'b1, ~OUT_MAX[47:0]};
		else                   return {1'b0, w[47:0]};
	endfunction

	state_t   state_q;
	step_t    step_q, nxt_step;
	logic     iter_start_q, mul_start_q;
	iter_op_t iter_op_q;
	logic     seen_q;
	logic signed [ACC_WIDTH-1:0] sums_q [4];
	logic     out_valid_q;
	logic signed [47:0] out_xx_q, out_xy_q, out_yx_q, out_yy_q;
	logic     out_ovf_q;

	pair_t              pair_q;
	logic [31:0]        r_q;
	logic [48:0]        rinv_q;
	logic [47:0]        q_q;
	logic signed [63:0] t_q, p6_q, d_q, deri_q, g_q;

	logic               take, root_done, recip_done, quot_done, mul_done, emit_go;
	logic               lj_w, sp_w, nxt_cont, seen_mul;
	logic [31:0]        sigma_mag;
	logic signed [63:0] eps64, a64, b64, d_w;
	logic [64:0]        br_c, dsum_c;
	logic signed [63:0] term;
	logic               term_sat;
	logic signed [ACC_WIDTH-1:0] term_n;
	logic [ACC_WIDTH:0] add0, add1, add2, add3;
	logic [48:0]        n0, n1, n2, n3;

	assign pop_ready  = state_q == ST_IDLE;
	assign take       = pop_ready & pop_valid;
	assign root_done  = (state_q == ST_ROOT) & iter_rsp.done;
	assign recip_done = (state_q == ST_RECIP) & iter_rsp.done;
	assign quot_done  = (state_q == ST_QUOT) & iter_rsp.done;
	assign mul_done   = (state_q == ST_MUL) & mul_rsp.done;
	assign emit_go    = (state_q == ST_EMIT) & pair_q.last & (~out_valid_q | result.ready);

	assign lj_w = (cfg.inner_radius > 0) && (r_q < unsigned'(cfg.inner_radius));
	assign sp_w = !lj_w && (cfg.cutoff_radius > 0) && (r_q < unsigned'(cfg.cutoff_radius));
	assign d_w  = $signed({32'd0, r_q}) - 64'(cfg.cutoff_radius);
	assign sigma_mag = cfg.sigma_length[31] ? unsigned'(-cfg.sigma_length)
		: unsigned'(cfg.sigma_length);
	assign eps64 = 64'(cfg.well_depth);

	assign iter_req.start   = iter_start_q;
	assign iter_req.op      = iter_op_q;
	assign iter_req.root_in = pair_q.r2;
	assign iter_req.den     = r_q;
	assign iter_req.num     = (state_q == ST_QUOT) ? {1'b0, sigma_mag, 16'd0}
		: {1'b1, 48'd0};

	// operand routing for each multiply step
	always_comb begin
		mul_req.start = mul_start_q;
		mul_req.shift = SH_16;
		mul_req.lim   = LIM_SAT;
		a64 = t_q;
		b64 = t_q;
		unique case (step_q)
			MS_P2:  begin a64 = {16'd0, q_q}; b64 = {16'd0, q_q}; end
			MS_P3:  b64 = {16'd0, q_q};
			MS_P6:  ;
			MS_P12: begin a64 = p6_q; b64 = p6_q; end
			MS_NUM: a64 = (eps64 <<< 4) + (eps64 <<< 3);
			MS_DLJ: begin b64 = {15'd0, rinv_q}; mul_req.shift = SH_32; end
			MS_D2:  begin a64 = d_q; b64 = d_q; end
			MS_T1:  a64 = (64'(cfg.spline_cubic) <<< 1) + 64'(cfg.spline_cubic);
			MS_T2:  begin a64 = 64'(cfg.spline_square) <<< 1; b64 = d_q; end
			MS_GXX: begin a64 = pair_q.xx; b64 = {15'd0, rinv_q}; mul_req.shift = SH_32; end
			MS_GXY: begin a64 = pair_q.xy; b64 = {15'd0, rinv_q}; mul_req.shift = SH_32; end
			MS_GYY: begin a64 = pair_q.yy; b64 = {15'd0, rinv_q}; mul_req.shift = SH_32; end
			MS_TXX, MS_TXY, MS_TYY: begin
				a64 = deri_q;
				b64 = g_q;
				mul_req.shift = SH_24;
				mul_req.lim   = BIG_SAT;
			end
			default: ;
		endcase
		mul_req.a = a64;
		mul_req.b = b64;
	end

	assign br_c   = clamp_lim(p6_q - (mul_rsp.res <<< 1));
	assign dsum_c = clamp_lim(t_q + mul_rsp.res);

	assign term     = mul_rsp.res;
	assign term_sat = (term > ACC_MAX) || (term < ACC_MIN);
	assign term_n   = term_sat ? (term[63] ? ACC_MIN[ACC_WIDTH-1:0] : ACC_MAX[ACC_WIDTH-1:0])
		: term[ACC_WIDTH-1:0];
	assign add0 = sat_add(sums_q[0], term_n);
	assign add1 = sat_add(sums_q[1], term_n);
	assign add2 = sat_add(sums_q[2], term_n);
	assign add3 = sat_add(sums_q[3], term_n);

	assign n0 = narrow_out(sums_q[0]);
	assign n1 = narrow_out(sums_q[1]);
	assign n2 = narrow_out(sums_q[2]);
	assign n3 = narrow_out(sums_q[3]);

	// next multiply step and saturation flags of the finishing one
	always_comb begin
		nxt_step = step_q;
		nxt_cont = 1'b1;
		seen_mul = mul_rsp.sat;
		unique case (step_q)
			MS_P2:  nxt_step = MS_P3;
			MS_P3:  nxt_step = MS_P6;
			MS_P6:  nxt_step = MS_P12;
			MS_P12: begin nxt_step = MS_NUM; seen_mul = mul_rsp.sat | br_c[64]; end
			MS_NUM: nxt_step = MS_DLJ;
			MS_DLJ: begin nxt_step = MS_GXX; nxt_cont = mul_rsp.res != '0; end
			MS_D2:  nxt_step = MS_T1;
			MS_T1:  nxt_step = MS_T2;
			MS_T2:  begin
				nxt_step = MS_GXX;
				nxt_cont = dsum_c[63:0] != '0;
				seen_mul = mul_rsp.sat | dsum_c[64];
			end
			MS_GXX: nxt_step = MS_TXX;
			MS_TXX: begin
				nxt_step = MS_GXY;
				seen_mul = mul_rsp.sat | term_sat | add0[ACC_WIDTH];
			end
			MS_GXY: nxt_step = MS_TXY;
			MS_TXY: begin
				nxt_step = MS_GYY;
				seen_mul = mul_rsp.sat | term_sat | add1[ACC_WIDTH] | add2[ACC_WIDTH];
			end
			MS_GYY: nxt_step = MS_TYY;
			MS_TYY: begin
				nxt_cont = 1'b0;
				seen_mul = mul_rsp.sat | term_sat | add3[ACC_WIDTH];
			end
			default: nxt_cont = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= MS_P2;
			iter_start_q <= 1'b0;
			iter_op_q    <= OP_ROOT;
			mul_start_q  <= 1'b0;
			seen_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < 4; i++) sums_q[i] <= '0;
		end else begin
			iter_start_q <= 1'b0;
			mul_start_q  <= 1'b0;
			if (result.ready && !emit_go) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q      <= ST_ROOT;
						iter_start_q <= 1'b1;
						iter_op_q    <= OP_ROOT;
						seen_q       <= seen_q | pop_data.ovf;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						if (iter_rsp.res == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q      <= ST_RECIP;
							iter_start_q <= 1'b1;
							iter_op_q    <= OP_DIV;
						end
					end
				end
				ST_RECIP: begin
					if (recip_done) begin
						if (lj_w) begin
							state_q      <= ST_QUOT;
							iter_start_q <= 1'b1;
						end else if (sp_w) begin
							state_q     <= ST_MUL;
							step_q      <= MS_D2;
							mul_start_q <= 1'b1;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_QUOT: begin
					if (quot_done) begin
						state_q     <= ST_MUL;
						step_q      <= MS_P2;
						mul_start_q <= 1'b1;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						seen_q <= seen_q | seen_mul;
						if (step_q == MS_TXX) sums_q[0] <= add0[ACC_WIDTH-1:0];
						if (step_q == MS_TXY) begin
							sums_q[1] <= add1[ACC_WIDTH-1:0];
							sums_q[2] <= add2[ACC_WIDTH-1:0];
						end
						if (step_q == MS_TYY) sums_q[3] <= add3[ACC_WIDTH-1:0];
						if (nxt_cont) begin
							step_q      <= nxt_step;
							mul_start_q <= 1'b1;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (!pair_q.last) begin
						state_q <= ST_IDLE;
					end else if (emit_go) begin
						out_valid_q <= 1'b1;
						seen_q      <= 1'b0;
						for (int i = 0; i < 4; i++) sums_q[i] <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) pair_q <= pop_data;
		if (root_done) r_q <= iter_rsp.res[31:0];
		if (recip_done) begin
			rinv_q <= iter_rsp.res;
			d_q    <= d_w;
		end
		if (quot_done) q_q <= iter_rsp.res[47:0];
		if (mul_done) begin
			unique case (step_q)
				MS_P6:                  begin t_q <= mul_rsp.res; p6_q <= mul_rsp.res; end
				MS_P12:                 t_q <= br_c[63:0];
				MS_DLJ:                 deri_q <= mul_rsp.res;
				MS_T2:                  deri_q <= dsum_c[63:0];
				MS_GXX, MS_GXY, MS_GYY: g_q <= mul_rsp.res;
				MS_TXX, MS_TXY, MS_TYY: ;
				default:                t_q <= mul_rsp.res;
			endcase
		end
		if (emit_go) begin
			out_xx_q  <= n0[47:0];
			out_xy_q  <= n1[47:0];
			out_yx_q  <= n2[47:0];
			out_yy_q  <= n3[47:0];
			out_ovf_q <= seen_q | n0[48] | n1[48] | n2[48] | n3[48];
		end
	end

	assign result.valid     = out_valid_q;
	assign result.stress_xx = out_xx_q;
	assign result.stress_xy = out_xy_q;
	assign result.stress_yx = out_yx_q;
	assign result.stress_yy = out_yy_q;
	assign result.overflow  = out_ovf_q;

endmodule

`default_nettype wire

@@ hw/rtl/pair_stress_accumulator.sv @@
// Pair stress accumulator. The back end takes a new pair only once it has finished the
// last one: at zero distance it runs only the root, past the cutoff the root and one
// divide, in the spline range and the Lennard-Jones range (two divides) also multiplies,
// stopping before the tensor steps when the slope is zero, all in the shared sequential units.
// A 2-entry queue lets the front end run ahead.
// Reset clears config registers, sums, overflow and all valid state.
`default_nettype none

module pair_stress_accumulator #(
	parameter int ACC_WIDTH = psa_pkg::ACC_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	psa_item_if.sink      item,
	psa_result_if.source  result,
	psa_cfg_if.sink       cfg
);
	import psa_pkg::*;

	cfg_t      cfg_q;
	logic      push_valid, push_ready, pop_valid, pop_ready;
	pair_t     push_data, pop_data;
	iter_req_t iter_req;
	iter_rsp_t iter_rsp;
	mul_req_t  mul_req;
	mul_rsp_t  mul_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_INNER:  cfg_q.inner_radius  <= cfg.data;
				REG_CUTOFF: cfg_q.cutoff_radius <= cfg.data;
				REG_WELL:   cfg_q.well_depth    <= cfg.data;
				REG_SIGMA:  cfg_q.sigma_length  <= cfg.data;
				REG_CUBIC:  cfg_q.spline_cubic  <= cfg.data;
				REG_SQUARE: cfg_q.spline_square <= cfg.data;
				default:    ;
			endcase
		end
	end

	psa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	psa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	psa_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iter_req),
		.rsp    (iter_rsp)
	);

	psa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	psa_back #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.iter_req  (iter_req),
		.iter_rsp  (iter_rsp),
		.mul_req   (mul_req),
		.mul_rsp   (mul_rsp),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ bench/psa_stress_check.sv @@
// Watches the item and result channels of the pair stress accumulator, predicts tensors.
// Depends on psa_pkg and the channel interfaces in psa_if.sv.
`timescale 1ns / 1ps

module psa_stress_check
	import psa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	psa_item_if.monitor   item,
	psa_result_if.monitor result,
	psa_cfg_if.monitor    cfg,
	output int           errors,
	output int           pending,
	output int           emitted
);

	typedef struct {
		logic signed [47:0] xx;
		logic signed [47:0] xy;
		logic signed [47:0] yx;
		logic signed [47:0] yy;
		logic               ovf;
	} tensor_t;

	localparam longint ACC_MAX = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	cfg_t        regs;
	longint      sums[4];
	bit          ovf_seen;
	tensor_t     tensor_q[$];

	assign pending = tensor_q.size();

	function automatic longint limit_to(longint v, longint lo, longint hi, ref bit ovf);
		if (v > hi) begin
			ovf = 1;
			return hi;
		end
		if (v < lo) begin
			ovf = 1;
			return lo;
		end
		return v;
	endfunction

	// Exact product, shifted, truncated toward zero, magnitude saturated.
	function automatic longint scaled_mul(longint a, longint b, int s,
			logic [63:0] lim, ref bit ovf);
		logic [127:0] p;
		logic [127:0] q;
		logic [63:0]  ma, mb;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ma  = a < 0 ? -a : a;
		mb  = b < 0 ? -b : b;
		p   = {64'd0, ma} * {64'd0, mb};
		q   = p >> s;
		if (q > {64'd0, lim}) begin
			q = {64'd0, lim};
			ovf = 1;
		end
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	task automatic add_component(int idx, longint slope, longint prod, longint rinv);
		longint g, t;
		g = scaled_mul(prod, rinv, 32, LIM, ovf_seen);
		t = limit_to(scaled_mul(slope, g, 24, BIG, ovf_seen), ACC_MIN, ACC_MAX, ovf_seen);
		if (t > 0 && sums[idx] > ACC_MAX - t) begin
			ovf_seen = 1;
			sums[idx] = ACC_MAX;
		end else if (t < 0 && sums[idx] < ACC_MIN - t) begin
			ovf_seen = 1;
			sums[idx] = ACC_MIN;
		end else begin
			sums[idx] += t;
		end
	endtask

	task automatic add_pair(longint cx, longint cy, longint nx, longint ny, bit last);
		longint      dx, dy, rinv, slope, q, p2, p3, p6, p12, br, num, d, d2, t1, t2;
		longint      ilim, r0, rc;
		logic [63:0] r2, r;
		tensor_t     t;
		ilim = longint'(LIM);
		r0 = regs.inner_radius;
		rc = regs.cutoff_radius;
		dx = limit_to(cx - nx, -64'sd2147483648, 64'sd2147483647, ovf_seen);
		dy = limit_to(cy - ny, -64'sd2147483648, 64'sd2147483647, ovf_seen);
		r2 = dx * dx + dy * dy;
		r = root_floor(r2);
		if (r != 0) begin
			rinv = longint'((64'd1 << 48) / r);
			slope = 0;
			if (r0 > 0 && r < r0) begin
				q = longint'(((regs.sigma_length < 0 ? -longint'(regs.sigma_length)
					: longint'(regs.sigma_length)) << 16) / r);
				p2 = scaled_mul(q, q, 16, LIM, ovf_seen);
				p3 = scaled_mul(p2, q, 16, LIM, ovf_seen);
				p6 = scaled_mul(p3, p3, 16, LIM, ovf_seen);
				p12 = scaled_mul(p6, p6, 16, LIM, ovf_seen);
				br = limit_to(p6 - 2 * p12, -ilim, ilim, ovf_seen);
				num = scaled_mul(24 * longint'(regs.well_depth), br, 16, LIM, ovf_seen);
				slope = scaled_mul(num, rinv, 32, LIM, ovf_seen);
			end else if (rc > 0 && r < rc) begin
				d = longint'(r) - rc;
				d2 = scaled_mul(d, d, 16, LIM, ovf_seen);
				t1 = scaled_mul(3 * longint'(regs.spline_cubic), d2, 16, LIM, ovf_seen);
				t2 = scaled_mul(2 * longint'(regs.spline_square), d, 16, LIM, ovf_seen);
				slope = limit_to(t1 + t2, -ilim, ilim, ovf_seen);
			end
			if (slope != 0) begin
				add_component(0, slope, dx * dx, rinv);
				add_component(1, slope, dx * dy, rinv);
				add_component(2, slope, dx * dy, rinv);
				add_component(3, slope, dy * dy, rinv);
			end
		end
		if (last) begin
			// ACC_WIDTH is 48, so output narrowing never clips here.
			t.xx = 48'(sums[0]);
			t.xy = 48'(sums[1]);
			t.yx = 48'(sums[2]);
			t.yy = 48'(sums[3]);
			t.ovf = ovf_seen;
			tensor_q = {tensor_q, t};
			sums = '{0, 0, 0, 0};
			ovf_seen = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tensor_t e;
		if (!arst_n) begin
			regs = '0;
			sums = '{0, 0, 0, 0};
			ovf_seen = 0;
			errors = 0;
			emitted = 0;
			tensor_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_INNER:  regs.inner_radius  = cfg.data;
					REG_CUTOFF: regs.cutoff_radius = cfg.data;
					REG_WELL:   regs.well_depth    = cfg.data;
					REG_SIGMA:  regs.sigma_length  = cfg.data;
					REG_CUBIC:  regs.spline_cubic  = cfg.data;
					REG_SQUARE: regs.spline_square = cfg.data;
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				emitted++;
				if (tensor_q.size() == 0) begin
					errors++;
					$error("stress tensor with no pending atom");
				end else begin
					e = tensor_q.pop_front();
					if (result.stress_xx !== e.xx) begin
						errors++;
						$error("stress_xx expected %0d got %0d", e.xx, result.stress_xx);
					end
					if (result.stress_xy !== e.xy) begin
						errors++;
						$error("stress_xy expected %0d got %0d", e.xy, result.stress_xy);
					end
					if (result.stress_yx !== e.yx) begin
						errors++;
						$error("stress_yx expected %0d got %0d", e.yx, result.stress_yx);
					end
					if (result.stress_yy !== e.yy) begin
						errors++;
						$error("stress_yy expected %0d got %0d", e.yy, result.stress_yy);
					end
					if (result.overflow !== e.ovf) begin
						errors++;
						$error("overflow expected %0d got %0d", e.ovf, result.overflow);
					end
				end
			end
			// Result handled first: a new tensor can't be emitted in the same cycle.
			if (item.valid && item.ready)
				add_pair(item.center_x, item.center_y, item.neighbor_x, item.neighbor_y,
					item.last_neighbor);
		end
	end

endmodule

@@ bench/pair_stress_accumulator_tb.sv @@
// Stimulus and verdict for the pair stress accumulator.
// Depends on psa_pkg, psa_if.sv and the checker in psa_stress_check.sv.
`timescale 1ns / 1ps

module pair_stress_accumulator_tb;
	import psa_pkg::*;

	localparam longint CYCLE_LIMIT = 2000000;

	logic   clk = 0;
	logic   arst_n = 0;
	int     errors, pending, emitted;
	longint cycles = 0;
	int     pairs_sent = 0;
	bit     hold_ready = 0;

	psa_item_if   item ();
	psa_result_if result ();
	psa_cfg_if    cfg ();

	pair_stress_accumulator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	psa_stress_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending),
		.emitted (emitted)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// Result-side backpressure.
	initial begin
		int n;
		result.ready = 0;
		@(posedge arst_n);
		forever begin
			n = hold_ready ? 0 : gap_len();
			if (n != 0) begin
				result.ready <= 0;
				repeat (n) @(posedge clk);
			end
			result.ready <= 1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// Leaves valid high; load_regs drops it after the last write.
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	// Leaves valid high after acceptance; the next call (after a gap) or wait_idle drops it.
	task automatic send_pair(logic [31:0] cx, cy, nx, ny, bit last);
		int n;
		n = gap_len();
		if (n != 0) begin
			item.valid <= 0;
			repeat (n) @(posedge clk);
		end
		item.valid         <= 1;
		item.center_x      <= cx;
		item.center_y      <= cy;
		item.neighbor_x    <= nx;
		item.neighbor_y    <= ny;
		item.last_neighbor <= last;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		pairs_sent++;
	endtask

	task automatic wait_idle();
		item.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic load_regs(logic [31:0] r0, rc, eps, s, a, b);
		write_reg(REG_INNER, r0);
		write_reg(REG_CUTOFF, rc);
		write_reg(REG_WELL, eps);
		write_reg(REG_SIGMA, s);
		write_reg(REG_CUBIC, a);
		write_reg(REG_SQUARE, b);
		cfg.valid <= 0;
	endtask

	// Random neighbor with offset below 2^span in Q16.16 units, or (one time in 20) all coordinates random.
	task automatic random_pair(int span, bit last);
		logic [31:0] cx, cy;
		int          dxr, dyr;
		cx = $urandom;
		cy = $urandom;
		if ($urandom_range(0, 19) == 0) begin
			send_pair($urandom, $urandom, $urandom, $urandom, last);
		end else begin
			dxr = $urandom_range(0, (1 << span) - 1);
			dyr = $urandom_range(0, (1 << span) - 1);
			if ($urandom_range(0, 1)) dxr = -dxr;
			if ($urandom_range(0, 1)) dyr = -dyr;
			send_pair(cx >> 2, cy >> 2, (cx >> 2) + dxr, (cy >> 2) + dyr, last);
		end
	endtask

	initial begin
		int phase, atoms, k;
		item.valid = 0;
		item.center_x = 0;
		item.center_y = 0;
		item.neighbor_x = 0;
		item.neighbor_y = 0;
		item.last_neighbor = 0;
		cfg.valid = 0;
		cfg.index = REG_INNER;
		cfg.data = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset registers, then a typical LJ/spline setup.
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1);
		send_pair(0, 0, 0, 0, 1);
		wait_idle();
		load_regs(32'h0002_0000, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0000_8000, 32'hFFFF_0000);
		send_pair(0, 0, 0, 0, 0);                           // zero distance
		send_pair(0, 0, 32'h0001_0000, 0, 0);               // Lennard-Jones
		send_pair(0, 0, 32'h0000_0100, 32'h0000_0100, 0);   // very close, saturates
		send_pair(0, 0, 32'h0003_0000, 32'h0000_8000, 0);   // spline
		send_pair(0, 0, 32'h0002_0000, 0, 0);               // exactly r0
		send_pair(0, 0, 32'h0004_0000, 0, 0);               // exactly rc
		send_pair(0, 0, 32'h0010_0000, 32'h0010_0000, 1);   // far
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1);
		send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
		wait_idle();
		// Negative radii and extreme coefficients.
		load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		send_pair(0, 0, 32'h0001_0000, 0, 1);
		wait_idle();
		load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(0, 0, 32'h0001_0000, 32'h0000_1000, 0);
		send_pair(0, 0, 32'h0100_0000, 0, 1);
		wait_idle();
		load_regs(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_pair(0, 0, 32'h00F0_0000, 32'h0F00_0000, 1);
		wait_idle();

		// Random phases: several register settings, atoms of a few neighbors each.
		for (phase = 0; phase < 8; phase++) begin
			if (phase % 4 == 3)
				load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else
				load_regs($urandom_range(32'h0000_8000, 32'h0003_0000),
					$urandom_range(32'h0003_0000, 32'h0008_0000),
					$urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
					$urandom_range(32'h0000_4000, 32'h0001_8000),
					$urandom - 32'h8000_0000 >>> 12,
					$urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
			hold_ready = (phase == 5);
			for (atoms = 0; atoms < 39; atoms++) begin
				k = $urandom_range(1, 6);
				for (int j = 0; j < k; j++)
					random_pair($urandom_range(12, 20), j == k - 1);
			end
			wait_idle();
		end

		wait_idle();
		$display("Sent %0d neighbor pairs over 13 register settings; %0d stress tensors checked.",
			pairs_sent, emitted);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
